@@ rtl/ntab_pkg.sv @@
// ----------------------------------------------------------------------------
// ntab_pkg
// Shared types, constants and helper functions of the neighbor table block.
// ----------------------------------------------------------------------------
package ntab_pkg;

   localparam int NTAB_DEPTH     = 32;     // default number of table entries
   localparam int ADDR_W         = 32;
   localparam int TIMER_W        = 16;
   localparam int CNT_W          = 9;      // holds any count up to 256 entries
   localparam int OUT_CNT_W      = 6;
   localparam int BETA_W         = 4;
   localparam logic [TIMER_W-1:0] HOLD_RESET = 16'd1000;

   localparam logic CMD_HEARD = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Request token handed from cell to cell along the chain.
   typedef struct packed {
      logic               active;
      logic               cmd;
      logic               hit;       // sender already present somewhere in the table
      logic               pending;   // new sender still looking for a free entry
      logic [ADDR_W-1:0]  addr;
      logic [CNT_W-1:0]   expired;
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WALK,
      ST_RESP
   } st_type;

   function automatic logic [OUT_CNT_W-1:0] sat63(input logic [CNT_W-1:0] v);
      logic [OUT_CNT_W-1:0] r;
      if (v > CNT_W'(63)) begin
         r = '1;
      end else begin
         r = v[OUT_CNT_W-1:0];
      end
      return r;
   endfunction

   // Beta in tenths: 10 below four neighbors, one tenth less per two more, floor 1.
   function automatic logic [BETA_W-1:0] beta_of(input logic [CNT_W-1:0] k);
      logic [CNT_W-1:0]  drop;
      logic [BETA_W-1:0] r;
      drop = (k - CNT_W'(2)) >> 1;
      if (k < CNT_W'(4)) begin
         r = BETA_W'(10);
      end else if (drop >= CNT_W'(9)) begin
         r = BETA_W'(1);
      end else begin
         r = BETA_W'(10) - drop[BETA_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/neighbor_table_aging_beta_top.sv @@
// ----------------------------------------------------------------------------
// neighbor_table_aging_beta_top
// Neighbor table with aging timers that sets the forwarding probability beta.
// ----------------------------------------------------------------------------
// Requests enter on req_*: req_tuser is the command (0 = packet heard,
// 1 = one time tick) and req_tdata the sender address. Every request gives
// exactly one response on rsp_*, carrying beta in tenths, the live neighbor
// count, a table full flag and the number of entries expired by a tick.
// hold_time is written through csr_valid/csr_ready/csr_data. The user must
// write it only while idle; the block itself does not enforce this.
// The table is a chain of TABLE_DEPTH cells. A request first passes a search
// state in which all cells compare the address, then its token moves one
// cell per cycle down the chain to a result register and on to the output
// register. One request is in the chain at a time, so a new request is
// accepted only once the previous response is loaded into the output
// register, where it may wait while the next request is accepted; a
// stalled receiver only holds the following response back in its final state.
// Reset clears all valid bits, the live count and the control state and
// sets hold_time to 1000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module neighbor_table_aging_beta_top
   import ntab_pkg::*;
#(
   parameter int TABLE_DEPTH = NTAB_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] src_addr
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] beta_tenths, [9:4] neighbor_count,
                                    // [10] table_full, [16:11] expired_count, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // hold_time
);

   localparam int LW = $clog2(TABLE_DEPTH + 1);

   st_type             state_ff, state_in;
   logic               cmd_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [TIMER_W-1:0] hold_ff;
   logic [LW-1:0]      live_ff, live_in;
   logic [16:0]        res_ff, res_in;
   logic [16:0]        rsp_data_ff;
   logic               rsp_valid_ff;
   logic               accept, tail_done, rsp_load;
   logic [CNT_W-1:0]   live_sum;
   logic [TABLE_DEPTH-1:0] match;
   tok_type            tok_head;
   tok_type            tok [TABLE_DEPTH+1];

   assign accept    = req_tvalid && req_tready;
   assign tail_done = tok[TABLE_DEPTH].active;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   // Head of the chain: the token starts right after the parallel compare.
   // A known sender never looks for a free entry.
   always_comb begin
      tok_head.active  = (state_ff == ST_SEARCH);
      tok_head.cmd     = cmd_ff;
      tok_head.hit     = |match;
      tok_head.pending = (cmd_ff == CMD_HEARD) && !(|match);
      tok_head.addr    = addr_ff;
      tok_head.expired = '0;
   end

   assign tok[0] = tok_head;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ntab_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .hold_time   (hold_ff),
         .search_addr (addr_ff),
         .tok_in      (tok[i]),
         .tok_out     (tok[i+1]),
         .match       (match[i])
      );
   end

   // Live count after the request that leaves the chain.
   always_comb begin
      live_sum = CNT_W'(live_ff);
      if (tok[TABLE_DEPTH].cmd == CMD_TICK) begin
         live_sum = live_sum - tok[TABLE_DEPTH].expired;
      end else if (!tok[TABLE_DEPTH].hit && !tok[TABLE_DEPTH].pending) begin
         live_sum = live_sum + CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      live_in  = live_ff;
      res_in   = res_ff;
      rsp_load = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (tail_done) begin
               live_in = LW'(live_sum);
               res_in  = {sat63(tok[TABLE_DEPTH].expired),
                          (tok[TABLE_DEPTH].cmd == CMD_HEARD) && tok[TABLE_DEPTH].pending,
                          sat63(live_sum),
                          beta_of(live_sum)};
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         hold_ff      <= HOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         if (csr_valid && csr_ready) begin
            hold_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (accept) begin
         cmd_ff  <= req_tuser;
         addr_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // The token only leaves the chain while the controller waits for it.
   assert property (@(posedge clock) disable iff (reset)
      tail_done |-> state_ff == ST_WALK)
      else $error("token left the chain outside the walk state");

   assert property (@(posedge clock) disable iff (reset)
      live_ff <= LW'(TABLE_DEPTH))
      else $error("live count exceeds table depth");

   // A response never reports both a dropped sender and expired entries.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[10] && (rsp_tdata[16:11] != 6'd0)))
      else $error("table full and expiry reported together");

   // Only one request is in the chain at a time.
   assert property (@(posedge clock) disable iff (reset)
      $countones({tok[0].active, tail_done}) <= 1)
      else $error("two requests in the chain");

endmodule

@@ rtl/ntab_cell.sv @@
// ----------------------------------------------------------------------------
// ntab_cell
// One table entry: valid bit, sender address and aging timer. Updates its
// entry when the request token passes and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ntab_cell
   import ntab_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [TIMER_W-1:0] hold_time,
   input  logic [ADDR_W-1:0]  search_addr,
   input  tok_type            tok_in,
   output tok_type            tok_out,
   output logic               match
);

   logic               valid_ff, valid_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   tok_type            tok_ff, tok_in_nxt;

   assign match   = valid_ff && (addr_ff == search_addr);
   assign tok_out = tok_ff;

   always_comb begin
      valid_in   = valid_ff;
      addr_in    = addr_ff;
      timer_in   = timer_ff;
      tok_in_nxt = tok_in;
      if (tok_in.active) begin
         if (tok_in.cmd == CMD_TICK) begin
            if (valid_ff) begin
               if (timer_ff <= TIMER_W'(1)) begin
                  valid_in           = 1'b0;
                  tok_in_nxt.expired = tok_in.expired + CNT_W'(1);
               end else begin
                  timer_in = timer_ff - TIMER_W'(1);
               end
            end
         end else if (tok_in.hit) begin
            if (valid_ff && (addr_ff == tok_in.addr)) begin
               timer_in = hold_time;
            end
         end else if (tok_in.pending && !valid_ff) begin
            // First free entry on the way claims the new sender.
            valid_in           = 1'b1;
            addr_in            = tok_in.addr;
            timer_in           = hold_time;
            tok_in_nxt.pending = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      timer_ff <= timer_in;
   end

endmodule

@@ tb/neighbor_table_aging_beta_top_tb.sv @@
// ----------------------------------------------------------------------------
// neighbor_table_aging_beta_top_tb
// Self-checking bench for the aging neighbor table and its beta output.
// ----------------------------------------------------------------------------
// A queue of heard-packet and tick requests feeds a clocked driver. On every
// accepted request the bench ages its own copy of the table and stores the
// status that the block should answer with. A clocked monitor checks each
// response field by field against the oldest stored status. hold_time is
// rewritten between phases, only after every response has come back. Both
// sides insert random idle cycles, and some phases run without idling.
// ----------------------------------------------------------------------------
module neighbor_table_aging_beta_top_tb;
   import ntab_pkg::*;

   localparam int DEPTH       = NTAB_DEPTH;
   localparam int BETA_MAX    = 10;
   localparam int BETA_MIN    = 1;
   localparam int SETTLE      = DEPTH + 8;     // covers a request's walk down the DEPTH-cell chain
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic        cmd;
      logic [31:0] addr;
   } nbr_req_type;

   // Response word, last field in the lowest bits.
   typedef struct packed {
      logic [6:0] pad;
      logic [5:0] expired;
      logic       full;
      logic [5:0] count;
      logic [3:0] beta;
   } nbr_status_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = CMD_HEARD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   neighbor_table_aging_beta_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Bench copy of the neighbor table.
   bit          nb_valid [DEPTH];
   logic [31:0] nb_addr  [DEPTH];
   logic [15:0] nb_timer [DEPTH];
   int unsigned nb_live;
   logic [15:0] hold_copy;

   nbr_req_type    req_q [$];
   nbr_status_type status_q [$];
   int             pending_rsp = 0;
   bit             idle_on = 1'b1;

   int errors        = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int ticks_sent    = 0;
   int full_hits     = 0;
   int expired_total = 0;
   int floor_hits    = 0;
   int hold_writes   = 0;
   int cycle_count   = 0;

   // Ages or updates the table copy for one request and returns the status.
   function automatic nbr_status_type next_status(input logic cmd, input logic [31:0] addr);
      nbr_status_type s;
      int          hit;
      int          free_slot;
      int unsigned expired;
      int unsigned drop;
      s         = '0;
      hit       = -1;
      free_slot = -1;
      expired   = 0;
      if (cmd == CMD_HEARD) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (nb_valid[i]) begin
               if (hit < 0 && nb_addr[i] == addr) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit >= 0) begin
            nb_timer[hit] = hold_copy;
         end else if (free_slot >= 0) begin
            nb_valid[free_slot] = 1'b1;
            nb_addr[free_slot]  = addr;
            nb_timer[free_slot] = hold_copy;
            nb_live++;
         end else begin
            s.full = 1'b1;
            full_hits++;
         end
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (nb_valid[i]) begin
               if (nb_timer[i] <= 16'd1) begin
                  nb_valid[i] = 1'b0;
                  expired++;
               end else begin
                  nb_timer[i] = nb_timer[i] - 16'd1;
               end
            end
         end
         nb_live -= expired;
         ticks_sent++;
         expired_total += expired;
      end
      if (nb_live < 4) begin
         s.beta = 4'(BETA_MAX);
      end else begin
         drop = (nb_live - 2) / 2;
         s.beta = (drop >= BETA_MAX - 1) ? 4'(BETA_MIN) : 4'(BETA_MAX - drop);
      end
      if (s.beta == 4'(BETA_MIN)) floor_hits++;
      s.count   = 6'(nb_live > 63 ? 63 : nb_live);
      s.expired = 6'(expired > 63 ? 63 : expired);
      return s;
   endfunction

   // Request driver.
   int          gap_left   = 0;
   bit          drain_wait = 1'b0;
   nbr_req_type cur_req;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= CMD_HEARD;
         gap_left   = 0;
         drain_wait = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_q.push_back(next_status(req_tuser, req_tdata));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (drain_wait && status_q.size() != 0) begin
               req_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
               cur_req    = req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_req.cmd;
               req_tdata  <= cur_req.addr;
               gap_left   = idle_on ? $urandom_range(0, 19) : 0;
               // Now and then hold the next request until the block has answered all.
               drain_wait = ($urandom_range(0, 59) == 0);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   int             stall_left = 0;
   nbr_status_type got;
   nbr_status_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (status_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected response %h with no request outstanding", rsp_tdata);
               end
            end else begin
               want = status_q.pop_front();
               pending_rsp--;
               checked_count++;
               if (got.beta !== want.beta || got.count !== want.count ||
                   got.full !== want.full || got.expired !== want.expired ||
                   got.pad !== want.pad) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("response %0d mismatch: beta %0d/%0d count %0d/%0d full %b/%b %s",
                              checked_count, want.beta, got.beta, want.count, got.count,
                              want.full, got.full, "(expected/actual)");
                     $display("   expired %0d/%0d pad %h/%h (expected/actual)",
                              want.expired, got.expired, want.pad, got.pad);
                  end
               end
            end
            stall_left = idle_on ? $urandom_range(0, 19) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_rsp);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_req(input logic cmd, input logic [31:0] addr);
      nbr_req_type r;
      r.cmd  = cmd;
      r.addr = addr;
      req_q.push_back(r);
      pending_rsp++;
   endtask

   // Returns at a rising edge once every response is in and the chain is quiet.
   task automatic wait_quiet();
      while (pending_rsp != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      hold_copy = value;
      hold_writes++;
      csr_valid <= 1'b0;
   endtask

   // Mostly addresses from a small pool so that hits, fills and drops all occur.
   task automatic queue_phase(input logic [15:0] hold, input int n, input int tick_pct,
                              input int pool_n, input bit idling);
      logic [31:0] pool [$];
      logic [31:0] addr;
      pool.delete();
      for (int i = 0; i < pool_n; i++) pool.push_back($urandom);
      if ($urandom_range(0, 1) == 1) begin
         pool[0] = '0;
         pool[1] = '1;
      end
      wait_quiet();
      write_hold(hold);
      idle_on = idling;
      for (int i = 0; i < n; i++) begin
         addr = $urandom;
         if ($urandom_range(0, 99) < tick_pct) begin
            queue_req(CMD_TICK, addr);
         end else begin
            if ($urandom_range(0, 7) != 0) addr = pool[$urandom_range(0, pool_n - 1)];
            queue_req(CMD_HEARD, addr);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         nb_valid[i] = 1'b0;
         nb_addr[i]  = '0;
         nb_timer[i] = '0;
      end
      nb_live   = 0;
      hold_copy = HOLD_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset hold time: insert, refresh, tick.
      queue_req(CMD_HEARD, 32'h0000_0000);
      queue_req(CMD_HEARD, 32'hFFFF_FFFF);
      queue_req(CMD_HEARD, 32'h0000_0000);
      queue_req(CMD_TICK, 32'hFFFF_FFFF);

      // Fill the table, overflow it, then let the short-lived entries expire
      // and insert a new sender into the lowest free slot.
      wait_quiet();
      write_hold(16'd2);
      for (int i = 0; i < DEPTH - 2; i++) queue_req(CMD_HEARD, 32'h0101_0101 * (i + 1));
      queue_req(CMD_HEARD, 32'h1234_5678);
      queue_req(CMD_HEARD, 32'hFFFF_FFFF);
      queue_req(CMD_TICK, 32'h0000_0000);
      queue_req(CMD_TICK, 32'h5555_AAAA);
      queue_req(CMD_HEARD, 32'h8000_0001);

      queue_phase(16'd1,     250, 20, 40, 1'b1);
      queue_phase(16'd4,     280, 25, 40, 1'b0);
      queue_phase(16'd12,    280, 12, 48, 1'b1);
      queue_phase(16'd2,     260, 35, 36, 1'b1);
      queue_phase(16'd30,    260,  8, 60, 1'b1);
      queue_phase(16'($urandom_range(3, 200)), 240, 15, 50, 1'b0);
      queue_phase(16'hFFFF,  280, 10, 45, 1'b1);

      wait_quiet();
      if (status_q.size() != 0) begin
         errors += status_q.size();
         $display("%0d expected responses never arrived", status_q.size());
      end

      $display("Checked %0d responses to %0d requests (%0d ticks) over %0d hold_time settings.",
               checked_count, sent_count, ticks_sent, hold_writes);
      $display("Table-full drops %0d, timer expirations %0d, responses at minimum beta %0d.",
               full_hits, expired_total, floor_hits);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/ntab_pkg.sv
rtl/ntab_cell.sv
rtl/neighbor_table_aging_beta_top.sv
tb/neighbor_table_aging_beta_top_tb.sv
